// File: rtl/tbc_pkg.sv
// Package for the tweakable block cipher: S-box, tweak permutation, round constants,
// and the command word from controller to datapath. No dependencies.
package tbc_pkg;

  localparam int unsigned RndW = 5;

  typedef struct packed {
    logic            load;
    logic            step;
    logic            finish;
    logic [RndW-1:0] round;
  } tbc_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [3:0] HPERM [16] = '{
    4'd6, 4'd9, 4'd12, 4'd3, 4'd2, 4'd5, 4'd8, 4'd15,
    4'd14, 4'd1, 4'd4, 4'd11, 4'd10, 4'd13, 4'd0, 4'd7
  };

  localparam logic [7:0] RCON [32] = '{
    8'h2f,8'h5e,8'hbc,8'h63,8'hc6,8'h97,8'h35,8'h6a,8'hd4,
    8'hb3,8'h7d,8'hfa,8'hef,8'hc5,8'h91,8'h39,8'h72,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
  };

  localparam logic [1:0] CfgKeyLow  = 2'd0;
  localparam logic [1:0] CfgKeyHigh = 2'd1;

  function automatic logic [127:0] h_perm(input logic [127:0] b);
    logic [127:0] t;
    for (int j = 0; j < 16; j++) t[8*j +: 8] = b[8*HPERM[j] +: 8];
    return t;
  endfunction

  function automatic logic [127:0] round_const(input logic [RndW-1:0] i);
    logic [127:0] c;
    c = '0;
    for (int j = 8; j < 12; j++) c[8*j +: 8] = RCON[i];
    c[8*12 +: 8] = 8'h08;
    c[8*13 +: 8] = 8'h04;
    c[8*14 +: 8] = 8'h02;
    c[8*15 +: 8] = 8'h01;
    return c;
  endfunction

  function automatic logic [127:0] lfsr2(input logic [127:0] b);
    logic [127:0] t;
    for (int j = 0; j < 16; j++)
      t[8*j +: 8] = {b[8*j +: 7], b[8*j+7] ^ b[8*j+5]};
    return t;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes_enc(input logic [127:0] s, input logic [127:0] k);
    logic [127:0] t;
    logic [127:0] o;
    logic [7:0]   a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
    for (int c = 0; c < 4; c++) begin
      a0  = t[8*(4*c)   +: 8];
      a1  = t[8*(4*c+1) +: 8];
      a2  = t[8*(4*c+2) +: 8];
      a3  = t[8*(4*c+3) +: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      o[8*(4*c)   +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      o[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      o[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      o[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return o ^ k;
  endfunction

endpackage

// File: rtl/tbc_if.sv
// Valid/ready channel interfaces for block input, cipher output and key writes.
// No dependencies.
interface tbc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_low;
  logic [63:0] block_high;
  logic [63:0] tweak_low;
  logic [63:0] tweak_high;
  modport source (output valid, block_low, block_high, tweak_low, tweak_high, input ready);
  modport sink (input valid, block_low, block_high, tweak_low, tweak_high, output ready);
endinterface

interface tbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_low;
  logic [63:0] cipher_high;
  modport source (output valid, cipher_low, cipher_high, input ready);
  modport sink (input valid, cipher_low, cipher_high, output ready);
endinterface

interface tbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/tweakable_block_cipher_encrypt.sv
// Tweakable block cipher, encryption only; 128-bit key, tweak and block.
// Each word takes one accept/whitening step, then ROUNDS rounds through the shared AES round
// unit, which sets the rate; the last round stalls while the output register is still full.
// Result lands in an output register; the next word is taken while it waits.
// Reset clears the key to zero and all handshake state; subkeys derive on the fly.
module tweakable_block_cipher_encrypt import tbc_pkg::*; #(
  parameter int unsigned ROUNDS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  tbc_in_if.sink    in_i,
  tbc_out_if.source out_o,
  tbc_cfg_if.sink   cfg_i
);

  tbc_cmd_t     cmd;
  logic [127:0] cipher;

  assign cfg_i.ready = 1'b1;

  tbc_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .cmd_o      (cmd)
  );

  tbc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_i.valid),
    .cfg_index_i(cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .block_i    ({in_i.block_high, in_i.block_low}),
    .tweak_i    ({in_i.tweak_high, in_i.tweak_low}),
    .cipher_o   (cipher)
  );

  assign out_o.cipher_low  = cipher[63:0];
  assign out_o.cipher_high = cipher[127:64];

  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (in_i.valid && in_i.ready)) else $error("load without accept");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready) else $error("accept while busy");
  a_finish_gives_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_o.valid) else $error("finished word not presented");
  a_finish_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_o.valid || out_o.ready)) else $error("result overwritten");

endmodule

// File: rtl/tbc_ctrl.sv
// Round sequencer for the cipher: accepts a word, counts rounds, hands off result.
// Depends on tbc_pkg.
module tbc_ctrl import tbc_pkg::*; #(
  parameter int unsigned ROUNDS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tbc_cmd_t cmd_o
);

  typedef enum logic {StIdle, StRun} state_e;

  state_e          state_q;
  logic [RndW-1:0] round_q;
  logic            out_valid_q;
  logic            out_free;
  logic            last;

  assign out_free   = !out_valid_q || out_ready_i;
  assign last       = (round_q == RndW'(ROUNDS));
  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  assign cmd_o.load   = (state_q == StIdle) && in_valid_i;
  assign cmd_o.step   = (state_q == StRun) && (!last || out_free);
  assign cmd_o.finish = (state_q == StRun) && last && out_free;
  assign cmd_o.round  = round_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !cmd_o.finish) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StRun;
            round_q <= RndW'(1);
          end
        end
        StRun: begin
          if (!last) begin
            round_q <= round_q + RndW'(1);
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// File: rtl/tbc_dp.sv
// Cipher datapath: key registers, on-the-fly subkey lane, tweak schedule, AES round,
// and the output register. Depends on tbc_pkg.
module tbc_dp import tbc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tbc_cmd_t     cmd_i,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,
  input  logic [127:0] block_i,
  input  logic [127:0] tweak_i,
  output logic [127:0] cipher_o
);

  logic [127:0] key_q;
  logic [127:0] state_q, tweak_q, lane_q, cipher_q;
  logic [127:0] k0, tweak_n, lane_n, round_out;

  assign k0        = key_q ^ round_const('0);
  assign tweak_n   = h_perm(tweak_q);
  assign lane_n    = h_perm(lfsr2(lane_q) ^ round_const(cmd_i.round));
  assign round_out = aes_enc(state_q, lane_n ^ tweak_n);
  assign cipher_o  = cipher_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == {6'd0, CfgKeyLow})  key_q[63:0]   <= cfg_data_i;
      if (cfg_index_i == {6'd0, CfgKeyHigh}) key_q[127:64] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      state_q <= block_i ^ k0 ^ tweak_i;
      tweak_q <= tweak_i;
      lane_q  <= k0;
    end else if (cmd_i.step) begin
      state_q <= round_out;
      tweak_q <= tweak_n;
      lane_q  <= lane_n;
    end
    if (cmd_i.finish) cipher_q <= round_out;
  end

endmodule
